// ===== src/heap_sort_defines.svh =====
// ----------------------------------------------------------------------------
// heap_sort_defines.svh
// Assertion macros for the heap sorter checks.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_DEFINES_SVH
`define HEAP_SORT_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define HS_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("heap_sort: check failed");

// next-cycle implication, clocked on clock, off during reset
`define HS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("heap_sort: check failed");

`endif

// ===== src/hs_pkg.sv =====
// ----------------------------------------------------------------------------
// hs_pkg
// Shared types for the heap sorter: payloads, controller states, commands.
// ----------------------------------------------------------------------------
`default_nettype none

package hs_pkg;

   localparam int unsigned DATA_W = 32;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     end_of_run;
      logic                     overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ROOT_RD,
      ST_ROOT_LATCH,
      ST_KID_RD,
      ST_KID_CMP,
      ST_HOLE_WR,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_EMIT,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic setup_build;
      logic root_read;
      logic latch_node;
      logic kid_read;
      logic cmp_step;
      logic hole_write;
      logic dec_i;
      logic setup_extract;
      logic swap_read;
      logic swap_write;
      logic emit_issue;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic n_lt2;
      logic kid_valid;
      logic sift_move;
      logic i_gt1;
      logic emit_last;
   } status_type;

endpackage

`default_nettype wire

// ===== src/hs_datapath.sv =====
// ----------------------------------------------------------------------------
// hs_datapath
// Element store, sift-down datapath, loop counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hs_datapath
   import hs_pkg::*;
#(
   parameter int unsigned DEPTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire req_type    req_data,
   output      status_type status,
   output      logic       rsp_valid,
   output      rsp_type    rsp_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned KW = AW + 2;

   logic signed [DATA_W-1:0] store_ff [DEPTH];
   logic signed [DATA_W-1:0] rdata_a_ff, rdata_b_ff;
   logic signed [DATA_W-1:0] node_val_ff, node_val_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     dropped_ff, dropped_in;
   logic [CW-1:0]            i_ff, i_in;
   logic [CW-1:0]            size_ff, size_in;
   logic [AW-1:0]            node_ff, node_in;
   logic [AW-1:0]            k_ff, k_in;
   logic                     rsp_valid_ff, rsp_end_ff, rsp_ovf_ff;

   logic [AW-1:0]            addr_a, addr_b, waddr;
   logic signed [DATA_W-1:0] wdata;
   logic                     we;
   logic [KW-1:0]            kid, kid2;
   logic [CW-1:0]            i_m1;
   logic                     kid2_valid, pick_b;
   logic signed [DATA_W-1:0] chosen_val;
   logic [KW-1:0]            chosen_idx;

   // heap index arithmetic
   always_comb begin
      kid        = (KW'(node_ff) << 1) + KW'(1);
      kid2       = kid + KW'(1);
      kid2_valid = kid2 < KW'(size_ff);
      i_m1       = i_ff - CW'(1);
      pick_b     = kid2_valid && (rdata_a_ff < rdata_b_ff);
      chosen_val = pick_b ? rdata_b_ff : rdata_a_ff;
      chosen_idx = pick_b ? kid2 : kid;
   end

   always_comb begin
      status.n_lt2     = count_ff < CW'(2);
      status.kid_valid = kid < KW'(size_ff);
      status.sift_move = !(chosen_val < node_val_ff);
      status.i_gt1     = i_ff > CW'(1);
      status.emit_last = (CW'(k_ff) + CW'(1)) == count_ff;
   end

   // read addresses, write port
   always_comb begin
      addr_a = k_ff;
      addr_b = kid2[AW-1:0];
      we     = 1'b0;
      waddr  = node_ff;
      wdata  = node_val_ff;
      if (cmd.root_read) begin
         addr_a = i_m1[AW-1:0];
      end else if (cmd.kid_read) begin
         addr_a = kid[AW-1:0];
      end else if (cmd.swap_read) begin
         addr_a = '0;
         addr_b = i_ff[AW-1:0];
      end
      if (cmd.load) begin
         we    = count_ff < CW'(DEPTH);
         waddr = count_ff[AW-1:0];
         wdata = req_data.value;
      end else if (cmd.cmp_step) begin
         we    = status.sift_move;
         wdata = chosen_val;
      end else if (cmd.hole_write) begin
         we = 1'b1;
      end else if (cmd.swap_write) begin
         we    = 1'b1;
         waddr = i_ff[AW-1:0];
         wdata = rdata_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_a_ff <= store_ff[addr_a];
      rdata_b_ff <= store_ff[addr_b];
   end

   always_comb begin
      count_in    = count_ff;
      dropped_in  = dropped_ff;
      i_in        = i_ff;
      size_in     = size_ff;
      node_in     = node_ff;
      node_val_in = node_val_ff;
      k_in        = k_ff;
      if (cmd.load) begin
         if (count_ff < CW'(DEPTH)) begin
            count_in = count_ff + CW'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.clear) begin
         count_in   = '0;
         dropped_in = 1'b0;
         k_in       = '0;
      end
      if (cmd.setup_build)   i_in = count_ff >> 1;
      if (cmd.setup_extract) i_in = count_ff - CW'(1);
      if (cmd.dec_i)         i_in = i_m1;
      if (cmd.root_read) begin
         node_in = i_m1[AW-1:0];
         size_in = count_ff;
      end
      if (cmd.latch_node) node_val_in = rdata_a_ff;
      if (cmd.cmp_step && status.sift_move) node_in = chosen_idx[AW-1:0];
      if (cmd.swap_write) begin
         node_val_in = rdata_b_ff;
         node_in     = '0;
         size_in     = i_ff;
      end
      if (cmd.emit_issue) k_in = k_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         k_ff         <= k_in;
         rsp_valid_ff <= cmd.emit_issue;
      end
      i_ff        <= i_in;
      size_ff     <= size_in;
      node_ff     <= node_in;
      node_val_ff <= node_val_in;
      rsp_end_ff  <= status.emit_last;
      rsp_ovf_ff  <= dropped_ff;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.sorted_value = rdata_a_ff;
   assign rsp_data.end_of_run   = rsp_end_ff;
   assign rsp_data.overflow     = rsp_ovf_ff;

endmodule

`default_nettype wire

// ===== src/hs_ctrl.sv =====
// ----------------------------------------------------------------------------
// hs_ctrl
// Sequencer for load, heap build, extraction and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module hs_ctrl
   import hs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       last,
   input  wire status_type status,
   output      logic       busy,
   output      cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      extract_ff, extract_in;   // 0: heap build, 1: extraction

   always_comb begin
      state_in   = state_ff;
      extract_in = extract_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && last) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            extract_in = 1'b0;
            state_in   = status.n_lt2 ? ST_EMIT : ST_ROOT_RD;
         end
         ST_ROOT_RD:    state_in = ST_ROOT_LATCH;
         ST_ROOT_LATCH: state_in = ST_KID_RD;
         ST_KID_RD:     state_in = status.kid_valid ? ST_KID_CMP : ST_HOLE_WR;
         ST_KID_CMP:    state_in = status.sift_move ? ST_KID_RD : ST_HOLE_WR;
         ST_HOLE_WR: begin
            if (!extract_ff) begin
               if (status.i_gt1) begin
                  state_in = ST_ROOT_RD;
               end else begin
                  state_in   = ST_SWAP_RD;
                  extract_in = 1'b1;
               end
            end else begin
               state_in = status.i_gt1 ? ST_SWAP_RD : ST_EMIT;
            end
         end
         ST_SWAP_RD: state_in = ST_SWAP_WR;
         ST_SWAP_WR: state_in = ST_KID_RD;
         ST_EMIT:    state_in = status.emit_last ? ST_DONE : ST_EMIT;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SETUP:      cmd.setup_build = !status.n_lt2;
         ST_ROOT_RD:    cmd.root_read = 1'b1;
         ST_ROOT_LATCH: cmd.latch_node = 1'b1;
         ST_KID_RD:     cmd.kid_read = status.kid_valid;
         ST_KID_CMP:    cmd.cmp_step = 1'b1;
         ST_HOLE_WR: begin
            cmd.hole_write    = 1'b1;
            cmd.dec_i         = status.i_gt1;
            cmd.setup_extract = !extract_ff && !status.i_gt1;
         end
         ST_SWAP_RD:    cmd.swap_read = 1'b1;
         ST_SWAP_WR:    cmd.swap_write = 1'b1;
         ST_EMIT:       cmd.emit_issue = 1'b1;
         ST_DONE:       cmd.clear = 1'b1;
         default:       cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         extract_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         extract_ff <= extract_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/heap_sort.sv =====
// ----------------------------------------------------------------------------
// heap_sort
// Batch sorter: loads signed values, heapsorts them in place, emits ascending.
// ----------------------------------------------------------------------------
//
//   channel   ports                    handshake
//   -------   ----------------------   ----------------------------------
//   request   start, busy, req_data    taken on an edge with start && !busy
//   result    rsp_valid, rsp_data      one-cycle strobe, cannot be stalled
//
// Loading: items are taken while idle; an item marked last starts the sort and
// busy stays high until the last result has been shown.
// Sift-down: root fetch (read, latch), then per level descended a child read
// and compare, ending on a compare that stops it or a final child check, then
// a hole write-back; n/2 sifts build the heap, n-1 (each after a root swap) extract.
// Emission: one result per cycle, the last during the clear cycle, then idle.
// Reset is synchronous; the store needs none, only count, flags, emit index and control.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort
   import hs_pkg::*;
#(
   parameter int unsigned DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   output      rsp_type rsp_data
);

   cmd_type    cmd;      // per-cycle datapath commands
   status_type status;   // compare and loop-bound results back to the sequencer

   // sequencer: load in idle, then build heap, extract, emit, clear
   hs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .last   (req_data.last),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // store, sift datapath and registered result
   hs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== src/hs_checker.sv =====
// ----------------------------------------------------------------------------
// hs_checker
// Port-level checks on the heap sorter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "heap_sort_defines.svh"

module hs_checker
   import hs_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // results appear only during a run
   `HS_ASSERT_NOW(a_rsp_in_run, rsp_valid, busy)
   // an item not marked last leaves the block ready
   `HS_ASSERT_NEXT(a_load_stays_idle, start && !busy && !req_data.last, !busy)
   // results of a batch come on consecutive cycles
   `HS_ASSERT_NEXT(a_rsp_contiguous, rsp_valid && !rsp_data.end_of_run, rsp_valid)
   // nothing follows the final result directly
   `HS_ASSERT_NEXT(a_end_closes, rsp_valid && rsp_data.end_of_run, !rsp_valid)

endmodule

bind heap_sort hs_checker u_hs_checker (.*);

`default_nettype wire
